>>> src/pvrm_pkg.sv
package pvrm_pkg;

  localparam int unsigned SAMPLE_DEPTH_DEF = 16384;
  localparam int unsigned FRAC_BITS_DEF    = 16;
  localparam int unsigned PADDR_W          = 5;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_VOLUME = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  localparam logic [2:0] REG_PITCH_STEP   = 3'd0;
  localparam logic [2:0] REG_LOOP_HEAD    = 3'd1;
  localparam logic [2:0] REG_LOOP_LIMIT   = 3'd2;
  localparam logic [2:0] REG_LOOP_REPEAT  = 3'd3;
  localparam logic [2:0] REG_SAMPLE_COUNT = 3'd4;

  localparam logic [23:0] PITCH_STEP_RST = 24'h01_0000;

  typedef enum logic [1:0] {OP_WRITE, OP_VOLUME, OP_START, OP_TICK} op_e;

  typedef struct packed {
    logic        [1:0]  kind;
    logic        [13:0] sample_addr;
    logic signed [15:0] sample_value;
    logic signed [15:0] vol_left;
    logic signed [15:0] vol_right;
    logic        [15:0] ramp_len;
    logic signed [31:0] acc_left_in;
    logic signed [31:0] acc_right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] acc_left_out;
    logic signed [31:0] acc_right_out;
    logic signed [15:0] clamped_left;
    logic signed [15:0] clamped_right;
    logic               playing;
  } out_item_t;

  typedef struct packed {
    op_e      op;
    in_item_t item;
  } cmd_t;

  typedef struct packed {
    logic        [23:0] pitch_step;
    logic        [13:0] loop_head;
    logic        [14:0] loop_limit;
    logic signed [8:0]  loop_repeat;
    logic        [14:0] sample_count;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] num;
    logic        [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [32:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) r = 16'sh7FFF;
    else if (v < -32'sd32768) r = -16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

>>> src/pvrm_stream_if.sv
interface pvrm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/pvrm_front.sv
module pvrm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pvrm_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output pvrm_pkg::cmd_t    cmd_o
);
  import pvrm_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t              queue_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [PTR_W:0]    count_q;
  cmd_t              cmd_new;
  logic              push, pop;

  // classify the item
  always_comb begin
    cmd_new.item = in_item_i;
    unique case (in_item_i.kind)
      KIND_WRITE:  cmd_new.op = OP_WRITE;
      KIND_VOLUME: cmd_new.op = OP_VOLUME;
      KIND_START:  cmd_new.op = OP_START;
      default:     cmd_new.op = OP_TICK;
    endcase
  end

  assign in_ready_o  = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) queue_q[wptr_q] <= cmd_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wptr_q + 1'b1;
      if (pop)  rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rptr_q + 1'b1;
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end
endmodule

>>> src/pvrm_div.sv
module pvrm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pvrm_pkg::div_req_t req_i,
  output pvrm_pkg::div_rsp_t rsp_o
);
  import pvrm_pkg::*;

  localparam int unsigned NW = 33;

  logic [NW-1:0] quo_q;
  logic [16:0]   rem_q;
  logic [15:0]   den_q;
  logic [5:0]    cnt_q;
  logic          busy_q, neg_q, done_q;
  logic [16:0]   rem_sh;
  logic          fits;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_q[15:0], quo_q[NW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      neg_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        neg_q  <= req_i.num[NW-1];
        quo_q  <= req_i.num[NW-1] ? NW'(-req_i.num) : NW'(req_i.num);
        rem_q  <= '0;
        den_q  <= req_i.den;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
        quo_q <= {quo_q[NW-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 6'(NW-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule

>>> src/pvrm_back.sv
module pvrm_back #(
  parameter int unsigned SAMPLE_DEPTH = pvrm_pkg::SAMPLE_DEPTH_DEF,
  parameter int unsigned FRAC_BITS    = pvrm_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  pvrm_pkg::cmd_t      cmd_i,
  input  pvrm_pkg::cfg_t      cfg_i,
  output pvrm_pkg::div_req_t  div_req_o,
  input  pvrm_pkg::div_rsp_t  div_rsp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pvrm_pkg::out_item_t out_o
);
  import pvrm_pkg::*;

  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);
  localparam int unsigned IW = 31 - FRAC_BITS;
  localparam int unsigned XW = (IW > 14) ? IW : 14;
  localparam int unsigned PW = 18 + FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_L, S_DIV_R, S_RD1, S_RD2, S_MUL, S_SUM, S_EMIT
  } state_e;

  state_e             state_q;
  logic [15:0]        store_q [SAMPLE_DEPTH];
  logic [15:0]        rd_data_q;
  logic               rd_ok_q;

  logic [30:0]        pos_q;
  logic signed [8:0]  loop_rem_q;
  logic               active_q;
  logic signed [31:0] gain_l_q, gain_r_q;
  logic signed [32:0] step_l_q, step_r_q;
  logic signed [15:0] tgt_l_q, tgt_r_q;
  logic [15:0]        ramp_q;

  logic [XW-1:0]        ipos_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic                 interp_q;
  logic signed [15:0]   s0_q;
  logic signed [PW-1:0] prod_q;
  logic signed [32:0]   mul_l_q, mul_r_q;
  logic signed [31:0]   res_l_q, res_r_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  // tick decode
  logic [XW-1:0]        ipos_cur, ipos_eff;
  logic [37:0]          ls_shift;
  logic [30:0]          pos_eff;
  logic                 wrap, go, interp_ok;
  logic [14:0]          lim;
  logic [XW:0]          rd_idx;
  logic                 wr_en;
  logic                 emit;
  logic signed [31:0]   vol_l_fix, vol_r_fix;
  logic signed [33:0]   num_l;
  logic signed [33:0]   num_r;
  logic signed [15:0]   s1;
  logic signed [16:0]   diff;
  logic signed [PW-1:0] prod_sh;
  logic signed [16:0]   s_int;
  logic signed [15:0]   gi_l, gi_r;
  logic signed [32:0]   sh_l, sh_r;
  logic signed [31:0]   gain_l_nx, gain_r_nx;

  always_comb begin
    ipos_cur = XW'(pos_q[30:FRAC_BITS]);
    ls_shift = 38'(cfg_i.loop_head) << FRAC_BITS;
    wrap     = (cfg_i.loop_limit != '0) && (32'(ipos_cur) >= 32'(cfg_i.loop_limit));
    pos_eff  = wrap ? ls_shift[30:0] : pos_q;
    ipos_eff = wrap ? XW'(cfg_i.loop_head) : ipos_cur;
    go       = !(wrap && (loop_rem_q == '0)) &&
               (32'(ipos_eff) < 32'(cfg_i.sample_count));
    lim      = (cfg_i.loop_limit != '0) ? cfg_i.loop_limit : cfg_i.sample_count;
    interp_ok = (pos_eff[FRAC_BITS-1:0] != '0) &&
                (32'(ipos_eff) + 32'd1 < 32'(lim));
    rd_idx   = (state_q == S_IDLE) ? (XW+1)'(ipos_eff) : (XW+1)'(ipos_q) + 1'b1;
  end

  assign wr_en = (state_q == S_IDLE) && cmd_valid_i && (cmd_i.op == OP_WRITE) &&
                 (32'(cmd_i.item.sample_addr) < SAMPLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (wr_en) store_q[AW'(cmd_i.item.sample_addr)] <= cmd_i.item.sample_value;
    rd_data_q <= store_q[AW'(rd_idx)];
  end

  // ramp divider requests: left from the idle decode, right when left is done
  always_comb begin
    vol_l_fix = {cmd_i.item.vol_left, 16'h0};
    vol_r_fix = {tgt_r_q, 16'h0};
    num_l     = 34'(vol_l_fix) - 34'(gain_l_q);
    num_r     = 34'(vol_r_fix) - 34'(gain_r_q);
    div_req_o.start = ((state_q == S_IDLE) && cmd_valid_i && (cmd_i.op == OP_VOLUME) &&
                       active_q && (cmd_i.item.ramp_len != '0)) ||
                      ((state_q == S_DIV_L) && div_rsp_i.done);
    div_req_o.num = (state_q == S_IDLE) ? num_l[32:0] : num_r[32:0];
    div_req_o.den = (state_q == S_IDLE) ? cmd_i.item.ramp_len : ramp_q;
  end

  // datapath terms
  always_comb begin
    s1      = rd_ok_q ? $signed(rd_data_q) : 16'sd0;
    diff    = 17'(s1) - 17'(s0_q);
    prod_sh = prod_q >>> FRAC_BITS;
    s_int   = 17'(s0_q) + 17'(prod_sh);
    if (prod_q[PW-1] && (prod_q[FRAC_BITS-1:0] != '0)) s_int = s_int + 17'sd1;
    gi_l = gain_l_q[31:16];
    if (gain_l_q[31] && (gain_l_q[15:0] != '0)) gi_l = gi_l + 16'sd1;
    gi_r = gain_r_q[31:16];
    if (gain_r_q[31] && (gain_r_q[15:0] != '0)) gi_r = gi_r + 16'sd1;
    sh_l = mul_l_q >>> 15;
    sh_r = mul_r_q >>> 15;
    gain_l_nx = sat32(34'(gain_l_q) + 34'(step_l_q));
    gain_r_nx = sat32(34'(gain_r_q) + 34'(step_r_q));
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign emit        = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_ok_q     <= 1'b0;
      pos_q       <= '0;
      loop_rem_q  <= '0;
      active_q    <= 1'b0;
      gain_l_q    <= '0;
      gain_r_q    <= '0;
      step_l_q    <= '0;
      step_r_q    <= '0;
      tgt_l_q     <= '0;
      tgt_r_q     <= '0;
      ramp_q      <= '0;
      ipos_q      <= '0;
      frac_q      <= '0;
      interp_q    <= 1'b0;
      s0_q        <= '0;
      prod_q      <= '0;
      mul_l_q     <= '0;
      mul_r_q     <= '0;
      res_l_q     <= '0;
      res_r_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      rd_ok_q <= 32'(rd_idx) < SAMPLE_DEPTH;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            res_l_q <= cmd_i.item.acc_left_in;
            res_r_q <= cmd_i.item.acc_right_in;
            unique case (cmd_i.op)
              OP_WRITE: state_q <= S_EMIT;
              OP_VOLUME: begin
                tgt_l_q <= cmd_i.item.vol_left;
                tgt_r_q <= cmd_i.item.vol_right;
                if (!active_q || (cmd_i.item.ramp_len == '0)) begin
                  gain_l_q <= {cmd_i.item.vol_left, 16'h0};
                  gain_r_q <= {cmd_i.item.vol_right, 16'h0};
                  step_l_q <= '0;
                  step_r_q <= '0;
                  ramp_q   <= '0;
                  state_q  <= S_EMIT;
                end else begin
                  ramp_q  <= cmd_i.item.ramp_len;
                  state_q <= S_DIV_L;
                end
              end
              OP_START: begin
                pos_q      <= '0;
                loop_rem_q <= cfg_i.loop_repeat;
                active_q   <= 1'b1;
                state_q    <= S_EMIT;
              end
              default: begin
                if (!active_q) begin
                  state_q <= S_EMIT;
                end else if ((cfg_i.sample_count == '0) || (cfg_i.pitch_step == '0)) begin
                  active_q <= 1'b0;
                  state_q  <= S_EMIT;
                end else begin
                  pos_q <= pos_eff;
                  if (wrap && (loop_rem_q != '0) && !loop_rem_q[8]) begin
                    loop_rem_q <= loop_rem_q - 9'sd1;
                  end
                  if (!go) begin
                    active_q <= 1'b0;
                    state_q  <= S_EMIT;
                  end else begin
                    ipos_q   <= ipos_eff;
                    frac_q   <= pos_eff[FRAC_BITS-1:0];
                    interp_q <= interp_ok;
                    state_q  <= S_RD1;
                  end
                end
              end
            endcase
          end
        end
        S_DIV_L: begin
          if (div_rsp_i.done) begin
            step_l_q <= div_rsp_i.quot;
            state_q  <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (div_rsp_i.done) begin
            step_r_q <= div_rsp_i.quot;
            state_q  <= S_EMIT;
          end
        end
        S_RD1: begin
          s0_q    <= rd_ok_q ? $signed(rd_data_q) : 16'sd0;
          state_q <= S_RD2;
        end
        S_RD2: begin
          prod_q  <= interp_q ? PW'(diff * $signed({1'b0, frac_q})) : '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          mul_l_q <= s_int * gi_l;
          mul_r_q <= s_int * gi_r;
          state_q <= S_SUM;
        end
        S_SUM: begin
          res_l_q <= sat32(34'(res_l_q) + 34'(sh_l));
          res_r_q <= sat32(34'(res_r_q) + 34'(sh_r));
          if (ramp_q != '0) begin
            ramp_q <= ramp_q - 1'b1;
            if (ramp_q == 16'd1) begin
              gain_l_q <= {tgt_l_q, 16'h0};
              gain_r_q <= {tgt_r_q, 16'h0};
              step_l_q <= '0;
              step_r_q <= '0;
            end else begin
              gain_l_q <= gain_l_nx;
              gain_r_q <= gain_r_nx;
            end
          end
          pos_q   <= pos_q + 31'(cfg_i.pitch_step);
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            out_q.acc_left_out  <= res_l_q;
            out_q.acc_right_out <= res_r_q;
            out_q.clamped_left  <= clamp16(res_l_q);
            out_q.clamped_right <= clamp16(res_r_q);
            out_q.playing       <= active_q;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> src/pcm_voice_resample_mix.sv
// Channel   Dir  Handshake        Payload
// in_i      in   valid/ready      kind, sample_addr, sample_value, vol_*, ramp_len, acc_*_in
// out_o     out  valid/ready      acc_*_out, clamped_*, playing
// apb       in   psel/penable     pitch_step, loop_head, loop_limit, loop_repeat, sample_count
//
// Sequence: write and start go straight to the result; a tick does two store reads
// over one read port, the interpolation multiply, the gain multiply and the sum; a
// ramped volume runs two 33-step divisions through one shared divider.
// Reset: rst_ni clears control state; the sample store holds garbage until written.
// Stalls: a two-entry queue decouples input from the executor, and the
// output register holds a result while the next item is taken in.
module pcm_voice_resample_mix #(
  parameter int unsigned SAMPLE_DEPTH = pvrm_pkg::SAMPLE_DEPTH_DEF,
  parameter int unsigned FRAC_BITS    = pvrm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pvrm_stream_if.sink                   in_i,
  pvrm_stream_if.source                 out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pvrm_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pvrm_pkg::*;

  cfg_t      cfg_q;
  logic      cfg_we;
  logic [2:0] reg_idx;
  logic      cmd_valid, cmd_ready;
  cmd_t      cmd;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  out_item_t out_item;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pitch_step   <= PITCH_STEP_RST;
      cfg_q.loop_head    <= '0;
      cfg_q.loop_limit   <= '0;
      cfg_q.loop_repeat  <= '0;
      cfg_q.sample_count <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_PITCH_STEP:   cfg_q.pitch_step   <= pwdata[23:0];
        REG_LOOP_HEAD:    cfg_q.loop_head    <= pwdata[13:0];
        REG_LOOP_LIMIT:   cfg_q.loop_limit   <= pwdata[14:0];
        REG_LOOP_REPEAT:  cfg_q.loop_repeat  <= pwdata[8:0];
        REG_SAMPLE_COUNT: cfg_q.sample_count <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PITCH_STEP:   prdata = 32'(cfg_q.pitch_step);
      REG_LOOP_HEAD:    prdata = 32'(cfg_q.loop_head);
      REG_LOOP_LIMIT:   prdata = 32'(cfg_q.loop_limit);
      REG_LOOP_REPEAT:  prdata = 32'(cfg_q.loop_repeat);
      REG_SAMPLE_COUNT: prdata = 32'(cfg_q.sample_count);
      default:          prdata = '0;
    endcase
  end

  // accept and classify, queue
  pvrm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_item_i   (in_i.data),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // shared divider for the volume ramp step
  pvrm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // execute: store, position, interpolation, gain, mix
  pvrm_back #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (out_item)
  );

  assign out_o.data = out_item;

  // clamped fields track the saturated sums
  a_clamp_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_item.clamped_left == clamp16(out_item.acc_left_out)))
    else $error("left clamp mismatch");

  a_clamp_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_item.clamped_right == clamp16(out_item.acc_right_out)))
    else $error("right clamp mismatch");

  // the divider only starts while the executor is waiting on a ramp setup
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (cmd_ready || div_rsp.done))
    else $error("divider started outside a volume transaction");
endmodule

>>> test/tb_pcm_voice_resample_mix.sv
module tb_pcm_voice_resample_mix;
  timeunit 1ns;
  timeprecision 1ps;

  import pvrm_pkg::*;

  // Playback stays inside samples 0..WIN, plus the last store entry.
  // All are written in the directed part, so no unwritten entry is ever read.
  localparam int unsigned WIN       = 16;
  localparam int unsigned LAST_IDX  = 16383;
  localparam int unsigned MAX_CYCLE = 800000;
  localparam int unsigned POS_MASK  = 32'h7FFF_FFFF;
  localparam longint      GAIN_ONE  = 65536;

  typedef struct {
    int unsigned pitch;
    int unsigned lstart;
    int unsigned lend;
    int          lrepeat;
    int unsigned scount;
  } voice_cfg_t;

  // Predicts one result per transaction and holds the results still to come.
  class voice_scoreboard;
    voice_cfg_t  cfg;
    shortint     store [SAMPLE_DEPTH_DEF];
    int unsigned position;
    int          loop_left;
    bit          active;
    int          gain_l, gain_r;
    longint      step_l, step_r;
    int          tgt_l, tgt_r;
    int unsigned ramp_left;
    out_item_t   pending_q[$];
    int          errors;

    function new();
      cfg.pitch = 65536; cfg.lstart = 0; cfg.lend = 0; cfg.lrepeat = 0; cfg.scount = 0;
      position = 0; loop_left = 0; active = 0;
      gain_l = 0; gain_r = 0; step_l = 0; step_r = 0;
      tgt_l = 0; tgt_r = 0; ramp_left = 0; errors = 0;
    endfunction

    function longint fetch(int unsigned idx);
      return (idx < SAMPLE_DEPTH_DEF) ? longint'(store[idx]) : 0;
    endfunction

    function longint sat_32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint clamp_16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void note_input(in_item_t it);
      longint      sum_l, sum_r, smp, diff;
      int unsigned ipos, frac, lim, len;
      bit          go;
      out_item_t   res;
      sum_l = longint'(it.acc_left_in);
      sum_r = longint'(it.acc_right_in);
      case (it.kind)
        KIND_WRITE: begin
          store[it.sample_addr] = it.sample_value;
        end
        KIND_VOLUME: begin
          len = it.ramp_len;
          tgt_l = int'(it.vol_left);
          tgt_r = int'(it.vol_right);
          if (!active || len == 0) begin
            gain_l = tgt_l * 65536;
            gain_r = tgt_r * 65536;
            step_l = 0; step_r = 0; ramp_left = 0;
          end else begin
            step_l = (longint'(tgt_l) * GAIN_ONE - longint'(gain_l)) / longint'(len);
            step_r = (longint'(tgt_r) * GAIN_ONE - longint'(gain_r)) / longint'(len);
            ramp_left = len;
          end
        end
        KIND_START: begin
          position = 0;
          loop_left = cfg.lrepeat;
          active = 1;
        end
        default: begin
          if (active) begin
            if (cfg.scount == 0 || cfg.pitch == 0) begin
              active = 0;
            end else begin
              ipos = position >> 16;
              go = 1;
              // Loop wrap: consume one repeat unless it repeats forever.
              if (cfg.lend > 0 && ipos >= cfg.lend) begin
                if (loop_left == 0) begin
                  go = 0;
                end else begin
                  if (loop_left > 0) loop_left--;
                  position = (cfg.lstart << 16) & POS_MASK;
                  ipos = cfg.lstart;
                end
              end
              if (go && ipos >= cfg.scount) go = 0;
              if (!go) begin
                active = 0;
              end else begin
                smp = fetch(ipos);
                frac = position & 32'hFFFF;
                if (frac != 0) begin
                  lim = (cfg.lend > 0) ? cfg.lend : cfg.scount;
                  if (ipos + 1 < lim) begin
                    diff = fetch(ipos + 1) - smp;
                    smp += (diff * longint'(frac)) / GAIN_ONE;
                  end
                end
                sum_l = sat_32(sum_l + ((smp * longint'(gain_l / 65536)) >>> 15));
                sum_r = sat_32(sum_r + ((smp * longint'(gain_r / 65536)) >>> 15));
                if (ramp_left > 0) begin
                  gain_l = int'(sat_32(longint'(gain_l) + step_l));
                  gain_r = int'(sat_32(longint'(gain_r) + step_r));
                  ramp_left--;
                  if (ramp_left == 0) begin
                    gain_l = tgt_l * 65536;
                    gain_r = tgt_r * 65536;
                    step_l = 0; step_r = 0;
                  end
                end
                position = (position + cfg.pitch) & POS_MASK;
              end
            end
          end
        end
      endcase
      res.acc_left_out  = sum_l[31:0];
      res.acc_right_out = sum_r[31:0];
      res.clamped_left  = 16'(clamp_16(sum_l));
      res.clamped_right = 16'(clamp_16(sum_r));
      res.playing       = active;
      pending_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.acc_left_out !== want.acc_left_out) begin
        $error("acc_left_out expected %0d actual %0d", want.acc_left_out, got.acc_left_out);
        errors++;
      end
      if (got.acc_right_out !== want.acc_right_out) begin
        $error("acc_right_out expected %0d actual %0d", want.acc_right_out, got.acc_right_out);
        errors++;
      end
      if (got.clamped_left !== want.clamped_left) begin
        $error("clamped_left expected %0d actual %0d", want.clamped_left, got.clamped_left);
        errors++;
      end
      if (got.clamped_right !== want.clamped_right) begin
        $error("clamped_right expected %0d actual %0d", want.clamped_right, got.clamped_right);
        errors++;
      end
      if (got.playing !== want.playing) begin
        $error("playing expected %0b actual %0b", want.playing, got.playing);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  pvrm_stream_if #(.T(in_item_t))  in_ch ();
  pvrm_stream_if #(.T(out_item_t)) out_ch ();

  pcm_voice_resample_mix dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  voice_scoreboard sb = new();
  bit          gaps_on = 1'b1;   // random idling on both sides
  int unsigned hold_req = 0;     // long receiver hold-off, in cycles
  int unsigned cycles = 0;

  always #5 clk_i = ~clk_i;

  // Abort a run that hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sample every result transaction at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Receiver: drop ready in random bursts, or for a long stretch on request.
  initial begin : receiver
    int unsigned stall;
    stall = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
        if (gaps_on && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 16);
      end
    end
  end

  // Offer one transaction; hold valid high until it is accepted.
  task automatic push_item(in_item_t it);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 16);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_input(it);
    @(negedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Drain all outstanding results, then reprogram every register.
  task automatic program_voice(voice_cfg_t c);
    in_ch.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    apb_write(REG_PITCH_STEP, c.pitch);
    apb_write(REG_LOOP_HEAD, c.lstart);
    apb_write(REG_LOOP_LIMIT, c.lend);
    apb_write(REG_LOOP_REPEAT, 32'(c.lrepeat) & 32'h1FF);
    apb_write(REG_SAMPLE_COUNT, c.scount);
    sb.cfg = c;
  endtask

  function automatic logic [31:0] rand_acc();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFF0 + $urandom_range(0, 15);
      1: return 32'h8000_0000 + $urandom_range(0, 15);
      2: return $urandom_range(0, 60000) - 30000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_item(logic [1:0] kind);
    in_item_t it;
    it.kind         = kind;
    it.sample_addr  = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, WIN - 1));
    it.sample_value = 16'($urandom);
    it.vol_left     = 16'($urandom);
    it.vol_right    = 16'($urandom);
    it.ramp_len     = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
    it.acc_left_in  = rand_acc();
    it.acc_right_in = rand_acc();
    return it;
  endfunction

  // Keep every reachable read inside the written window or the last entry.
  function automatic voice_cfg_t rand_cfg();
    voice_cfg_t c;
    case ($urandom_range(0, 9))
      0: c.pitch = 24'hFF_FFFF;
      1: c.pitch = 1;
      2: c.pitch = $urandom_range(1, 24'hFF_FFFF);
      default: c.pitch = $urandom_range(1, 24'h03_FFFF);
    endcase
    c.lrepeat = $urandom_range(0, 255) - 1;
    if ($urandom_range(0, 4) == 0) begin
      c.scount = 16384;
      c.lend   = $urandom_range(1, WIN);
      c.lstart = ($urandom_range(0, 3) == 0) ? LAST_IDX : $urandom_range(0, WIN - 1);
    end else begin
      c.scount = $urandom_range(1, WIN);
      case ($urandom_range(0, 3))
        0: c.lend = 0;
        1: c.lend = 16384;
        default: c.lend = $urandom_range(1, WIN);
      endcase
      c.lstart = ($urandom_range(0, 3) == 0) ? 14'($urandom) : $urandom_range(0, WIN - 1);
    end
    return c;
  endfunction

  initial begin : stimulus
    in_item_t   it;
    voice_cfg_t c;
    int unsigned n_items, r;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fill the playback window and the last store entry; first two words at the extremes.
    for (int i = 0; i <= WIN + 1; i++) begin
      it = make_item(KIND_WRITE);
      it.sample_addr  = (i == WIN + 1) ? 14'(LAST_IDX) : 14'(i);
      if (i == 0) it.sample_value = 16'sh7FFF;
      if (i == 1) it.sample_value = -16'sh8000;
      push_item(it);
    end
    // Volume while idle jumps at once; a tick with zero sample count stops the voice.
    it = make_item(KIND_VOLUME);
    it.vol_left = -16'sh8000; it.vol_right = 16'sh7FFF; it.ramp_len = 16'd5;
    push_item(it);
    push_item(make_item(KIND_START));
    push_item(make_item(KIND_TICK));

    // Fractional pitch with a short loop, a ramp while active, then zero pitch.
    c.pitch = 24'h00_8000; c.lstart = 2; c.lend = 6; c.lrepeat = 1; c.scount = WIN;
    program_voice(c);
    push_item(make_item(KIND_START));
    it = make_item(KIND_VOLUME);
    it.vol_left = 16'sh7FFF; it.vol_right = -16'sh8000; it.ramp_len = 16'd3;
    push_item(it);
    repeat (4) push_item(make_item(KIND_TICK));
    it = make_item(KIND_VOLUME);
    it.ramp_len = 16'hFFFF;
    push_item(it);
    push_item(make_item(KIND_TICK));
    c.pitch = 0;
    program_voice(c);
    push_item(make_item(KIND_START));
    push_item(make_item(KIND_TICK));

    // Random phases: each a fresh setting, a start, then mostly ticks.
    for (int ph = 0; ph < 14; ph++) begin
      c = rand_cfg();
      if (ph == 0) begin
        c.pitch = 24'hFF_FFFF; c.scount = 16384; c.lend = WIN; c.lstart = LAST_IDX;
        c.lrepeat = -1;
      end
      if (ph == 1) begin
        c.pitch = 1; c.scount = WIN; c.lend = 16384; c.lstart = 0; c.lrepeat = 254;
      end
      program_voice(c);
      gaps_on = (ph < 12);
      if (ph == 3) hold_req = 400;  // let the input side back up
      n_items = 120;
      push_item(make_item(KIND_START));
      for (int k = 0; k < n_items; k++) begin
        r = $urandom_range(0, 99);
        if (r < 15) push_item(make_item(KIND_WRITE));
        else if (r < 25) push_item(make_item(KIND_VOLUME));
        else if (r < 32) push_item(make_item(KIND_START));
        else push_item(make_item(KIND_TICK));
      end
    end

    in_ch.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
